>>> src/gas_compressibility_factor_unit_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the gas compressibility factor unit
// Shared property forms, clocked on clk and disabled while rst is high.
// ---------------------------------------------------------------------------
`ifndef GAS_COMPRESSIBILITY_FACTOR_UNIT_DEFINES_SVH
`define GAS_COMPRESSIBILITY_FACTOR_UNIT_DEFINES_SVH

// Same-cycle implication
`define GCF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define GCF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/gcf_pkg.sv
// ---------------------------------------------------------------------------
// gcf_pkg
// Types, widths and fixed-point virial coefficients for the Z-factor unit.
// ---------------------------------------------------------------------------
`default_nettype none

package gcf_pkg;

  // Field widths
  localparam int P_W     = 20;
  localparam int SHARE_W = 10;
  localparam int Z_W     = 26;

  // Internal widths: mixed coefficients and Horner products
  localparam int COEF_W = 29;
  localparam int D_W    = 41;
  localparam int PROD_W = D_W + P_W + 1;

  // Fixed-point scaling
  localparam int WORK_BITS                = 56;
  localparam int STEP_BITS                = 20;
  localparam int RESULT_FRACTION_BITS_DEF = 24;

  localparam int SHARE_FULL = 1000;

  typedef logic        [P_W-1:0]     p_t;
  typedef logic        [SHARE_W-1:0] share_t;
  typedef logic signed [COEF_W-1:0]  coef_t;
  typedef logic signed [D_W-1:0]     d_t;
  typedef logic signed [PROD_W-1:0]  prod_t;
  typedef logic        [Z_W-1:0]     z_t;

  // Per-gas coefficients, scaled to mbar and permille (first, second, third order)
  localparam coef_t K1_O2 = -29'sd51743987;
  localparam coef_t K2_O2 =  29'sd212961783;
  localparam coef_t K3_O2 = -29'sd119072497;
  localparam coef_t K1_N2 = -29'sd15799374;
  localparam coef_t K2_N2 =  29'sd221267309;
  localparam coef_t K3_N2 = -29'sd164488347;
  localparam coef_t K1_HE =  29'sd35115109;
  localparam coef_t K2_HE = -29'sd6676542;
  localparam coef_t K3_HE =  29'sd4225274;

  // Stage enables of one Horner step
  typedef struct packed {
    logic mul_en;
    logic add_en;
  } hstep_en_t;

  // Weight three coefficients by the gas shares and sum
  function automatic d_t mix3(input share_t o2, input share_t n2, input share_t he,
                              input coef_t k_o2, input coef_t k_n2, input coef_t k_he);
    d_t w_o2;
    d_t w_n2;
    d_t w_he;
    w_o2 = d_t'($signed({1'b0, o2}));
    w_n2 = d_t'($signed({1'b0, n2}));
    w_he = d_t'($signed({1'b0, he}));
    return w_o2 * d_t'(k_o2) + w_n2 * d_t'(k_n2) + w_he * d_t'(k_he);
  endfunction

endpackage

`default_nettype wire

>>> src/gcf_in_if.sv
// ---------------------------------------------------------------------------
// gcf_in_if
// Sample channel: pressure and mix shares with valid/ready handshake.
// ---------------------------------------------------------------------------
`default_nettype none

interface gcf_in_if;
  logic                 valid;
  logic                 ready;
  gcf_pkg::p_t          pressure_mbar;
  gcf_pkg::share_t      oxygen_permille;
  gcf_pkg::share_t      helium_permille;

  modport source (output valid, output pressure_mbar, output oxygen_permille,
                  output helium_permille, input ready);
  modport sink   (input valid, input pressure_mbar, input oxygen_permille,
                  input helium_permille, output ready);
endinterface

`default_nettype wire

>>> src/gcf_out_if.sv
// ---------------------------------------------------------------------------
// gcf_out_if
// Result channel: Z factor and mix flag with valid/ready handshake.
// ---------------------------------------------------------------------------
`default_nettype none

interface gcf_out_if;
  logic        valid;
  logic        ready;
  gcf_pkg::z_t z_factor;
  logic        mix_error;

  modport source (output valid, output z_factor, output mix_error, input ready);
  modport sink   (input valid, input z_factor, input mix_error, output ready);
endinterface

`default_nettype wire

>>> src/gcf_mix.sv
// ---------------------------------------------------------------------------
// gcf_mix
// One register stage: mixed first-, second- and third-order coefficients.
// ---------------------------------------------------------------------------
`default_nettype none

module gcf_mix (
  input  wire logic            clk,
  input  wire logic            en,
  input  wire gcf_pkg::share_t o2,
  input  wire gcf_pkg::share_t n2,
  input  wire gcf_pkg::share_t he,
  output gcf_pkg::d_t          d1,
  output gcf_pkg::d_t          d2,
  output gcf_pkg::d_t          d3
);

  // Weight each order by the shares; advance on enable
  always_ff @(posedge clk) begin
    if (en) begin
      d1 <= gcf_pkg::mix3(o2, n2, he, gcf_pkg::K1_O2, gcf_pkg::K1_N2, gcf_pkg::K1_HE);
      d2 <= gcf_pkg::mix3(o2, n2, he, gcf_pkg::K2_O2, gcf_pkg::K2_N2, gcf_pkg::K2_HE);
      d3 <= gcf_pkg::mix3(o2, n2, he, gcf_pkg::K3_O2, gcf_pkg::K3_N2, gcf_pkg::K3_HE);
    end
  end

endmodule

`default_nettype wire

>>> src/gcf_hstep.sv
// ---------------------------------------------------------------------------
// gcf_hstep
// One Horner step in two stages: multiply by pressure, then round and add.
// ---------------------------------------------------------------------------
`default_nettype none

module gcf_hstep (
  input  wire logic               clk,
  input  wire gcf_pkg::hstep_en_t en,
  input  wire gcf_pkg::d_t        coef,
  input  wire gcf_pkg::d_t        addend,
  input  wire gcf_pkg::p_t        p_in,
  output gcf_pkg::d_t             acc,
  output gcf_pkg::p_t             p_out
);

  localparam gcf_pkg::prod_t HALF = gcf_pkg::prod_t'(1) <<< (gcf_pkg::STEP_BITS - 1);

  gcf_pkg::prod_t prod;
  gcf_pkg::d_t    addend_mid;
  gcf_pkg::p_t    p_mid;
  gcf_pkg::prod_t rounded;

  // Multiply stage: pressure is zero-extended into the signed product
  always_ff @(posedge clk) begin
    if (en.mul_en) begin
      prod       <= gcf_pkg::prod_t'(coef)
                    * gcf_pkg::prod_t'($signed({1'b0, p_in}));
      addend_mid <= addend;
      p_mid      <= p_in;
    end
  end

  // Round half up on the step shift
  assign rounded = (prod + HALF) >>> gcf_pkg::STEP_BITS;

  // Add stage
  always_ff @(posedge clk) begin
    if (en.add_en) begin
      acc   <= gcf_pkg::d_t'(rounded) + addend_mid;
      p_out <= p_mid;
    end
  end

endmodule

`default_nettype wire

>>> src/gas_compressibility_factor_unit.sv
// Gas compressibility factor unit: takes pressure in mbar and oxygen and helium
// shares in permille, and returns Z = 1 + cubic virial term as unsigned fixed
// point with RESULT_FRACTION_BITS fraction bits, saturated to 26 bits, plus a
// flag when oxygen and helium together exceed 1000 permille (nitrogen is then
// zero). The datapath is an eight-stage pipeline: share check, coefficient
// mixing, two Horner steps of multiply then round-and-add, a final multiply,
// and round, offset and clamp into the output register. One transaction is
// taken every cycle unless a stall reaches the input stage, and a stalled
// output only holds back stages that are occupied.
// ---------------------------------------------------------------------------
// gas_compressibility_factor_unit
// Top level: pipeline control, share check and final scaling.
// ---------------------------------------------------------------------------
`default_nettype none

`include "gas_compressibility_factor_unit_defines.svh"

module gas_compressibility_factor_unit #(
  parameter int RESULT_FRACTION_BITS = gcf_pkg::RESULT_FRACTION_BITS_DEF
) (
  input wire logic clk,
  input wire logic rst,
  gcf_in_if.sink   sample,
  gcf_out_if.source result
);

  localparam int NS     = 8;
  localparam int ZSHIFT = gcf_pkg::WORK_BITS - RESULT_FRACTION_BITS;

  localparam gcf_pkg::prod_t HALF_Z = gcf_pkg::prod_t'(1) <<< (ZSHIFT - 1);
  localparam gcf_pkg::prod_t ONE_Z  = gcf_pkg::prod_t'(1) <<< RESULT_FRACTION_BITS;
  localparam gcf_pkg::prod_t Z_MAX  = (gcf_pkg::prod_t'(1) <<< gcf_pkg::Z_W)
                                      - gcf_pkg::prod_t'(1);
  localparam logic [gcf_pkg::SHARE_W:0] SHARE_SUM_FULL =
    (gcf_pkg::SHARE_W + 1)'(gcf_pkg::SHARE_FULL);

  // Pipeline control
  logic [NS-1:0] vld;
  logic [NS-1:0] en;
  logic [NS-1:0] err_pipe;

  // Stage 0: input and share check
  gcf_pkg::p_t     p0;
  gcf_pkg::share_t o2_0;
  gcf_pkg::share_t he_0;
  gcf_pkg::share_t n2_0;
  logic [gcf_pkg::SHARE_W:0] share_sum;
  logic            over;

  // Later stages
  gcf_pkg::d_t    d1;
  gcf_pkg::d_t    d2;
  gcf_pkg::d_t    d3;
  gcf_pkg::p_t    p1;
  gcf_pkg::d_t    d1_s2;
  gcf_pkg::d_t    d1_s3;
  gcf_pkg::d_t    a2;
  gcf_pkg::p_t    p_a;
  gcf_pkg::d_t    a1;
  gcf_pkg::p_t    p_b;
  gcf_pkg::prod_t m0;
  gcf_pkg::prod_t z_sum;
  gcf_pkg::z_t    z_next;
  gcf_pkg::z_t    z_q;

  gcf_pkg::hstep_en_t en_a;
  gcf_pkg::hstep_en_t en_b;

  // Stage enables: a stage advances when empty or when the next one advances
  always_comb begin
    en[NS-1] = !vld[NS-1] || result.ready;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  // Refuse input while reset is held
  assign sample.ready = en[0] && !rst;

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= sample.valid;
      end
      for (int k = 1; k < NS; k++) begin
        if (en[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  // Carry the mix flag alongside the data
  always_ff @(posedge clk) begin
    if (en[0]) begin
      err_pipe[0] <= over;
    end
    for (int k = 1; k < NS; k++) begin
      if (en[k]) begin
        err_pipe[k] <= err_pipe[k-1];
      end
    end
  end

  // Nitrogen is the remainder; drop it to zero for an oversized mix
  assign share_sum = {1'b0, sample.oxygen_permille} + {1'b0, sample.helium_permille};
  assign over      = share_sum > SHARE_SUM_FULL;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      p0   <= sample.pressure_mbar;
      o2_0 <= sample.oxygen_permille;
      he_0 <= sample.helium_permille;
      n2_0 <= over ? '0 : gcf_pkg::SHARE_W'(SHARE_SUM_FULL - share_sum);
    end
  end

  // Stage 1: mixed coefficients
  gcf_mix u_mix (
    .clk (clk),
    .en  (en[1]),
    .o2  (o2_0),
    .n2  (n2_0),
    .he  (he_0),
    .d1  (d1),
    .d2  (d2),
    .d3  (d3)
  );

  always_ff @(posedge clk) begin
    if (en[1]) begin
      p1 <= p0;
    end
  end

  // Hold the first-order coefficient until the second Horner step needs it
  always_ff @(posedge clk) begin
    if (en[2]) begin
      d1_s2 <= d1;
    end
    if (en[3]) begin
      d1_s3 <= d1_s2;
    end
  end

  // Stages 2 and 3: a2 = rnd(D3 * p) + D2
  assign en_a.mul_en = en[2];
  assign en_a.add_en = en[3];

  gcf_hstep u_step_a (
    .clk    (clk),
    .en     (en_a),
    .coef   (d3),
    .addend (d2),
    .p_in   (p1),
    .acc    (a2),
    .p_out  (p_a)
  );

  // Stages 4 and 5: a1 = rnd(a2 * p) + D1
  assign en_b.mul_en = en[4];
  assign en_b.add_en = en[5];

  gcf_hstep u_step_b (
    .clk    (clk),
    .en     (en_b),
    .coef   (a2),
    .addend (d1_s3),
    .p_in   (p_a),
    .acc    (a1),
    .p_out  (p_b)
  );

  // Stage 6: final multiply
  always_ff @(posedge clk) begin
    if (en[6]) begin
      m0 <= gcf_pkg::prod_t'(a1) * gcf_pkg::prod_t'($signed({1'b0, p_b}));
    end
  end

  // Stage 7: round to the result scale, add one and clamp
  assign z_sum = ((m0 + HALF_Z) >>> ZSHIFT) + ONE_Z;

  always_comb begin
    if (z_sum < 0) begin
      z_next = '0;
    end else if (z_sum > Z_MAX) begin
      z_next = '1;
    end else begin
      z_next = gcf_pkg::Z_W'(z_sum);
    end
  end

  always_ff @(posedge clk) begin
    if (en[7]) begin
      z_q <= z_next;
    end
  end

  assign result.valid     = vld[NS-1];
  assign result.z_factor  = z_q;
  assign result.mix_error = err_pipe[NS-1];

  // Checks
  `GCF_ASSERT_NEXT(a_accept_fills, sample.valid && sample.ready, vld[0],
                   "accepted transaction not held in first stage")
  `GCF_ASSERT_NEXT(a_stall_keeps, vld[3] && !en[3], vld[3],
                   "stalled stage lost its transaction")
  `GCF_ASSERT_NOW(a_share_split, vld[0] && !err_pipe[0],
                  ({1'b0, o2_0} + {1'b0, he_0} + {1'b0, n2_0}) == SHARE_SUM_FULL,
                  "shares do not add up to the full mix")
  `GCF_ASSERT_NOW(a_ready_when_empty, !result.valid, sample.ready,
                  "input refused with an empty output stage")

endmodule

`default_nettype wire
